// File: hdl/mac_address_text_parser_defines.svh
// assertion macros for the hardware-address text parser
// expects signals named clk and rst_n in the scope of each use
`ifndef MAC_ADDRESS_TEXT_PARSER_DEFINES_SVH
`define MAC_ADDRESS_TEXT_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MTP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtp assertion failed");
`define MTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtp assertion failed");
`else
`define MTP_ASSERT_SAME(lbl, ante, cons)
`define MTP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/mtp_pkg.sv
// types, character codes and the character classifier of the address parser
// no dependencies
package mtp_pkg;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam int unsigned NIBBLE_BITS = 4;
    localparam int unsigned ADDR_W      = 48;

    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_SEP   = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_EOT   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [NIBBLE_BITS-1:0] nib;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    // sort one character into digit, separator, end of text or anything else
    function automatic item_t classify(input logic [7:0] code, input logic eot);
        item_t r;
        r.kind = KIND_BAD;
        r.nib  = code[3:0];
        if (eot)
        begin
            r.kind = KIND_EOT;
        end
        else if (code == CHAR_COLON || code == CHAR_HYPHEN)
        begin
            r.kind = KIND_SEP;
        end
        else if (code >= 8'h30 && code <= 8'h39)
        begin
            r.kind = KIND_DIGIT;
        end
        else if ((code >= 8'h61 && code <= 8'h66) || (code >= 8'h41 && code <= 8'h46))
        begin
            // low nibble of a..f / A..F is 1..6
            r.kind = KIND_DIGIT;
            r.nib  = 4'(code[3:0] + 4'd9);
        end
        return r;
    endfunction

endpackage

// File: hdl/mtp_char_if.sv
// character channel of the address parser: valid/ready plus one character
// depends on nothing
interface mtp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// File: hdl/mtp_result_if.sv
// result channel of the address parser: valid/ready plus status and address
// depends on nothing
interface mtp_result_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic [47:0] address;

    modport source (output valid, output parse_ok, output address, input ready);
    modport sink   (input valid, input parse_ok, input address, output ready);
endinterface

// File: hdl/mtp_in_stage.sv
// input register: classifies each character as it is taken in
// depends on mtp_pkg
module mtp_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      char_code,
    input  logic            end_of_text,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            advance,
    output mtp_pkg::stage_t stage
);

    logic           valid_reg;
    mtp_pkg::item_t item_reg;
    logic           take;

    // stage may refill in the same cycle it drains
    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= mtp_pkg::classify(char_code, end_of_text);
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: hdl/mtp_core.sv
// parse state (accumulator, digit count, error flag) and the result register
// depends on mtp_pkg
module mtp_core
#(
    parameter int unsigned ADDRESS_BYTES = 6
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  mtp_pkg::stage_t stage,
    output logic            advance,
    output logic            res_valid,
    input  logic            res_ready,
    output logic            parse_ok,
    output logic [47:0]     address
);

    localparam int unsigned ACC_W  = 8 * ADDRESS_BYTES;
    localparam int unsigned CNT_W  = $clog2(2 * ADDRESS_BYTES + 1);
    localparam logic [CNT_W-1:0] DIGITS = CNT_W'(2 * ADDRESS_BYTES);

    logic [ACC_W-1:0] acc_reg,   acc_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             err_reg,   err_next;
    logic             out_valid_reg;
    logic             ok_reg;
    logic [47:0]      addr_reg;
    logic             out_free;
    logic             is_eot;
    logic             ok_now;

    assign is_eot   = stage.item.kind == mtp_pkg::KIND_EOT;
    assign out_free = !out_valid_reg || res_ready;
    // only an end-of-text item needs room in the result register
    assign advance  = stage.valid && (!is_eot || out_free);
    assign ok_now   = !err_reg && (cnt_reg == DIGITS);

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (advance)
        begin
            case (stage.item.kind)
                mtp_pkg::KIND_EOT:
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    err_next = 1'b0;
                end
                mtp_pkg::KIND_BAD:
                begin
                    err_next = 1'b1;
                end
                mtp_pkg::KIND_DIGIT:
                begin
                    if (!err_reg)
                    begin
                        if (cnt_reg == DIGITS)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = {acc_reg[ACC_W-mtp_pkg::NIBBLE_BITS-1:0],
                                        stage.item.nib};
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // separators change nothing
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            if (advance && is_eot)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_eot)
        begin
            ok_reg   <= ok_now;
            addr_reg <= ok_now ? mtp_pkg::ADDR_W'(acc_reg) : '0;
        end
    end

    assign res_valid = out_valid_reg;
    assign parse_ok  = ok_reg;
    assign address   = addr_reg;

endmodule

// File: hdl/mac_address_text_parser.sv
// top level of the hardware-address text parser
// depends on mtp_pkg, mtp_char_if, mtp_result_if, mtp_in_stage, mtp_core and the defines header
//
// chars: one text character per item (char_code, end_of_text). colons and
// hyphens are skipped, hex digits of either case are shifted in first digit
// most significant, anything else or one digit too many marks the text bad.
// result: one item per end-of-text item, parse_ok and address; address is
// zero when parse_ok is 0. parse state is cleared after each end-of-text.
// an end-of-text passes the input register, then the result register.
// throughput: one character per cycle but while an end-of-text waits, set
// by the state update between the input register and the result register.
// reset clears the input register, the result register and the parse state;
// chars.ready is high right after reset.
// while result is stalled, ordinary characters still flow in; an
// end-of-text waits in the input register until the result is taken, and
// chars.ready drops only behind that waiting end-of-text.
`include "mac_address_text_parser_defines.svh"

module mac_address_text_parser
#(
    parameter int unsigned ADDRESS_BYTES = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    mtp_char_if.sink    chars,
    mtp_result_if.source result
);

    mtp_pkg::stage_t stage;
    logic            advance;
    logic            stage_eot;
    logic            result_stalled;

    mtp_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (chars.char_code),
        .end_of_text (chars.end_of_text),
        .in_valid    (chars.valid),
        .in_ready    (chars.ready),
        .advance     (advance),
        .stage       (stage)
    );

    mtp_core #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .parse_ok  (result.parse_ok),
        .address   (result.address)
    );

    assign stage_eot      = stage.valid && stage.item.kind == mtp_pkg::KIND_EOT;
    assign result_stalled = result.valid && !result.ready;

    `MTP_ASSERT_NEXT(a_eot_gives_result, advance && stage_eot, result.valid)
    `MTP_ASSERT_SAME(a_fail_zero_addr, result.valid && !result.parse_ok, result.address == 48'd0)
    `MTP_ASSERT_SAME(a_empty_stage_ready, !stage.valid, chars.ready)
    `MTP_ASSERT_SAME(a_eot_blocked, stage_eot && result_stalled, !advance && !chars.ready)

endmodule
